// ----- src/mie_pkg.sv -----
package mie_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned COEF_W = 34;
    localparam int unsigned INV_W  = 31;
    localparam int unsigned CNT_W  = 5;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_DIV,
        S_UPDATE,
        S_FINISH
    } state_t;

endpackage

// ----- src/modular_inverse_euclid.sv -----
// Modular multiplicative inverse by the extended Euclidean algorithm. Each input
// transaction carries a signed value and a signed modulus (only its magnitude is
// used) and yields one output transaction with the inverse and a status: ok, no
// inverse, or zero modulus. A single shared unit does one restoring-division
// bit per cycle and, in the Euclid rounds, in the same cycle one step of the
// quotient times coefficient product. The value is first reduced modulo the
// modulus by the divider, then each Euclid round runs 32 divide steps plus
// check and update; a zero modulus goes straight to the result.
// s_axis_tready is high only while no item is in progress.
module modular_inverse_euclid
    import mie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // value [31:0], modulus [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // inverse [30:0], status [32:31], zero pad
);

    state_t                     state_reg, state_next;
    logic                       out_valid_reg, out_valid_next;
    logic [INV_W-1:0]           out_inv_reg, out_inv_next;
    status_t                    out_st_reg, out_st_next;
    logic [INV_W-1:0]           res_inv_reg, res_inv_next;
    status_t                    res_st_reg, res_st_next;

    logic [WORD_W-1:0]          m_reg, m_next;
    logic                       neg_reg, neg_next;
    logic [WORD_W-1:0]          r_reg, r_next;
    logic [WORD_W-1:0]          nr_reg, nr_next;
    logic signed [COEF_W-1:0]   t_reg, t_next;
    logic signed [COEF_W-1:0]   nt_reg, nt_next;
    logic [WORD_W-1:0]          rem_reg, rem_next;
    logic [WORD_W-1:0]          quo_reg, quo_next;
    logic [WORD_W-1:0]          div_reg, div_next;
    logic signed [COEF_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;

    logic [WORD_W-1:0]          in_value;
    logic [WORD_W-1:0]          in_modulus;
    logic [WORD_W-1:0]          mag_value;
    logic [WORD_W-1:0]          mag_modulus;
    logic [WORD_W:0]            shifted;
    logic [WORD_W+1:0]          diff;
    logic                       qbit;
    logic [WORD_W-1:0]          rem_step;
    logic signed [COEF_W-1:0]   acc_step;
    logic signed [COEF_W-1:0]   t_lift;

    assign in_value    = s_axis_tdata[31:0];
    assign in_modulus  = s_axis_tdata[63:32];
    assign mag_value   = in_value[WORD_W-1] ? (~in_value + 1'b1) : in_value;
    assign mag_modulus = in_modulus[WORD_W-1] ? (~in_modulus + 1'b1) : in_modulus;

    // shared divide and multiply-accumulate step
    assign shifted  = {rem_reg, quo_reg[WORD_W-1]};
    assign diff     = {1'b0, shifted} - {2'b00, div_reg};
    assign qbit     = ~diff[WORD_W+1];
    assign rem_step = qbit ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
    assign acc_step = (acc_reg <<< 1) + (qbit ? nt_reg : '0);
    assign t_lift   = t_reg + $signed({2'b00, m_reg});

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_st_reg, out_inv_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_inv_reg <= out_inv_next;
        out_st_reg  <= out_st_next;
        res_inv_reg <= res_inv_next;
        res_st_reg  <= res_st_next;
        m_reg       <= m_next;
        neg_reg     <= neg_next;
        r_reg       <= r_next;
        nr_reg      <= nr_next;
        t_reg       <= t_next;
        nt_reg      <= nt_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        div_reg     <= div_next;
        acc_reg     <= acc_next;
        cnt_reg     <= cnt_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_inv_next   = out_inv_reg;
        out_st_next    = out_st_reg;
        res_inv_next   = res_inv_reg;
        res_st_next    = res_st_reg;
        m_next         = m_reg;
        neg_next       = neg_reg;
        r_next         = r_reg;
        nr_next        = nr_reg;
        t_next         = t_reg;
        nt_next        = nt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    m_next   = mag_modulus;
                    neg_next = in_value[WORD_W-1];
                    quo_next = mag_value;
                    rem_next = '0;
                    div_next = mag_modulus;
                    acc_next = '0;
                    cnt_next = '0;
                    if (mag_modulus == '0)
                    begin
                        res_inv_next = '0;
                        res_st_next  = ST_ZERO;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_REDUCE;
                    end
                end
            end

            S_REDUCE:
            begin
                rem_next = rem_step;
                quo_next = {quo_reg[WORD_W-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    r_next  = m_reg;
                    t_next  = '0;
                    nt_next = COEF_W'(1);
                    if (!neg_reg)
                    begin
                        nr_next = rem_step;
                    end
                    else if (rem_step == '0)
                    begin
                        nr_next = '0;
                    end
                    else
                    begin
                        nr_next = m_reg - rem_step;
                    end
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (nr_reg == '0)
                begin
                    if (r_reg > WORD_W'(1))
                    begin
                        res_inv_next = '0;
                        res_st_next  = ST_NONE;
                    end
                    else
                    begin
                        res_inv_next = t_reg[COEF_W-1] ? t_lift[INV_W-1:0] : t_reg[INV_W-1:0];
                        res_st_next  = ST_OK;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    quo_next   = r_reg;
                    rem_next   = '0;
                    div_next   = nr_reg;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                rem_next = rem_step;
                quo_next = {quo_reg[WORD_W-2:0], qbit};
                acc_next = acc_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                nt_next    = t_reg - acc_reg;
                t_next     = nt_reg;
                nr_next    = rem_reg;
                r_next     = nr_reg;
                state_next = S_CHECK;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_inv_next   = res_inv_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/mie_checker.sv -----
module mie_checker
    import mie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata
);

    // a stalled result transaction holds its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    // status is one of the three defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[32:31] == ST_OK || m_axis_tdata[32:31] == ST_NONE
                           || m_axis_tdata[32:31] == ST_ZERO))
        else $error("undefined status code");

    // inverse is zero unless status is ok
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[32:31] != ST_OK |-> m_axis_tdata[30:0] == '0)
        else $error("nonzero inverse with failing status");

    // one item at a time: input closes right after a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while item in progress");

    // no result rises as the direct effect of an accepted input, not even for a zero modulus
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !(m_axis_tvalid && $rose(m_axis_tvalid)))
        else $error("result appeared without finishing stage");

endmodule

bind modular_inverse_euclid mie_checker u_mie_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
